[hw/rtl/rctr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rctr_pkg
// Shared types and constants of the transmitter report decoder.
// ---------------------------------------------------------------------------
package rctr_pkg;

   localparam logic [7:0] REPORT_LEN = 8'd8;
   localparam logic [7:0] REPORT_ID  = 8'd5;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_BAD_LENGTH = 2'd1;
   localparam logic [1:0] STATUS_BAD_ID     = 2'd2;

   localparam logic [1:0] CSR_DEADZONE   = 2'd0;
   localparam logic [1:0] CSR_STICK_GAIN = 2'd1;
   localparam logic [1:0] CSR_DIAL_MODE  = 2'd2;

   localparam logic [6:0]  DEADZONE_RESET   = 7'd5;
   localparam logic [15:0] STICK_GAIN_RESET = 16'd23406;
   localparam logic [15:0] UNITY_GAIN       = 16'd16384;

   localparam logic signed [15:0] AXIS_ONE     = 16'sd16384;
   localparam logic signed [15:0] AXIS_NEG_ONE = -16'sd16384;

   localparam int TRIM_COUNT = 10;
   localparam logic [7:0] TRIM_PATTERNS [TRIM_COUNT] = '{
      8'ha2, 8'h51, 8'h36, 8'h1b, 8'h12, 8'h09, 8'h06, 8'h03, 8'h02, 8'h01
   };

   typedef struct packed {
      logic [6:0]  deadzone;
      logic [15:0] stick_gain;
      logic        dial_mode;
   } rctr_cfg_type;

   typedef struct packed {
      logic [7:0] report_length;
      logic [7:0] report_id;
      logic [7:0] aileron_byte;
      logic [7:0] elevator_byte;
      logic [7:0] throttle_byte;
      logic [7:0] dial_byte;
      logic [7:0] rudder_byte;
      logic [7:0] trim_byte;
      logic [7:0] switch_byte;
   } rctr_report_type;

   typedef struct packed {
      logic signed [15:0] axis_rudder;
      logic signed [15:0] axis_throttle;
      logic signed [15:0] axis_aileron;
      logic signed [15:0] axis_elevator;
      logic signed [15:0] axis_aux;
      logic signed [7:0]  dial_delta;
      logic [17:0]        button_bits;
   } rctr_held_type;

endpackage
`default_nettype wire

[hw/rtl/rctr_axis_scale.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rctr_axis_scale
// Centers one axis byte, applies the deadzone, scales by gain and clamps
// to plus or minus one in Q1.14.
// ---------------------------------------------------------------------------
module rctr_axis_scale
   import rctr_pkg::*;
(
   input  logic [7:0]         axis_byte,
   input  logic [6:0]         deadzone,
   input  logic [15:0]        gain,
   output logic signed [15:0] axis_value
);

   logic signed [8:0]  centered;
   logic [7:0]         magnitude;
   logic signed [16:0] gain_signed;
   logic signed [25:0] product;
   logic signed [18:0] shifted;

   always_comb begin
      centered    = $signed({1'b0, axis_byte}) - 9'sd128;
      magnitude   = centered[8] ? 8'(-centered) : 8'(centered);
      gain_signed = $signed({1'b0, gain});
      product     = 26'(centered) * 26'(gain_signed);
      // arithmetic shift, rounds toward minus infinity
      shifted     = product[25:7];
      if (magnitude < {1'b0, deadzone}) begin
         axis_value = '0;
      end else if (shifted > 19'sd16384) begin
         axis_value = AXIS_ONE;
      end else if (shifted < -19'sd16384) begin
         axis_value = AXIS_NEG_ONE;
      end else begin
         axis_value = shifted[15:0];
      end
   end

endmodule
`default_nettype wire

[hw/rtl/rctr_trim_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rctr_trim_decode
// Greedy pattern removal decode of the trim switch byte.
// ---------------------------------------------------------------------------
module rctr_trim_decode
   import rctr_pkg::*;
(
   input  logic [7:0]            trim_byte,
   output logic [TRIM_COUNT-1:0] trim_buttons
);

   logic [7:0] residue;

   always_comb begin
      residue      = trim_byte;
      trim_buttons = '0;
      for (int i = 0; i < TRIM_COUNT; i++) begin
         if ((residue & TRIM_PATTERNS[i]) == TRIM_PATTERNS[i]) begin
            residue = residue ^ TRIM_PATTERNS[i];
            trim_buttons[TRIM_COUNT-1-i] = 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

[hw/rtl/rc_transmitter_report_decoder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rc_transmitter_report_decoder_unit
// Decodes one transmitter report per beat into axes, dial delta and buttons.
// Path: the req beat is captured in the input register, then decoded into the result register that drives rsp_valid.
// Throughput: one report per cycle while the result register can drain; decode is one pass of logic.
// Reset: synchronous; clears held axes, delta, buttons, last dial position,
// and loads deadzone 5, stick gain 23406, aux axis mode.
// ---------------------------------------------------------------------------
module rc_transmitter_report_decoder_unit
   import rctr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_report_length,
   input  logic [7:0]         req_report_id,
   input  logic [7:0]         req_aileron_byte,
   input  logic [7:0]         req_elevator_byte,
   input  logic [7:0]         req_throttle_byte,
   input  logic [7:0]         req_dial_byte,
   input  logic [7:0]         req_rudder_byte,
   input  logic [7:0]         req_trim_byte,
   input  logic [7:0]         req_switch_byte,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [15:0] rsp_axis_rudder,
   output logic signed [15:0] rsp_axis_throttle,
   output logic signed [15:0] rsp_axis_aileron,
   output logic signed [15:0] rsp_axis_elevator,
   output logic signed [15:0] rsp_axis_aux,
   output logic signed [7:0]  rsp_dial_delta,
   output logic [17:0]        rsp_button_bits,

   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);

   rctr_cfg_type    cfg_ff, cfg_in;
   rctr_report_type s1_report_ff, s1_report_in;
   rctr_held_type   held_ff, held_in;
   logic            s1_valid_ff, s1_valid_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      status_ff, status_in;
   logic [7:0]      last_dial_ff, last_dial_in;

   logic            req_fire;
   logic            advance;
   logic            decode_ok;
   logic signed [15:0] rudder_value, throttle_value, aileron_value;
   logic signed [15:0] elevator_value, aux_value;
   logic [TRIM_COUNT-1:0] trim_buttons;

   assign csr_ready = 1'b1;
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   rctr_axis_scale u_rudder (
      .axis_byte  (s1_report_ff.rudder_byte),
      .deadzone   (cfg_ff.deadzone),
      .gain       (cfg_ff.stick_gain),
      .axis_value (rudder_value)
   );

   rctr_axis_scale u_throttle (
      .axis_byte  (s1_report_ff.throttle_byte),
      .deadzone   (cfg_ff.deadzone),
      .gain       (cfg_ff.stick_gain),
      .axis_value (throttle_value)
   );

   rctr_axis_scale u_aileron (
      .axis_byte  (s1_report_ff.aileron_byte),
      .deadzone   (cfg_ff.deadzone),
      .gain       (cfg_ff.stick_gain),
      .axis_value (aileron_value)
   );

   rctr_axis_scale u_elevator (
      .axis_byte  (s1_report_ff.elevator_byte),
      .deadzone   (cfg_ff.deadzone),
      .gain       (cfg_ff.stick_gain),
      .axis_value (elevator_value)
   );

   rctr_axis_scale u_aux (
      .axis_byte  (s1_report_ff.dial_byte),
      .deadzone   (cfg_ff.deadzone),
      .gain       (UNITY_GAIN),
      .axis_value (aux_value)
   );

   rctr_trim_decode u_trim (
      .trim_byte    (s1_report_ff.trim_byte),
      .trim_buttons (trim_buttons)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEADZONE:   cfg_in.deadzone   = csr_data[6:0];
            CSR_STICK_GAIN: cfg_in.stick_gain = csr_data;
            CSR_DIAL_MODE:  cfg_in.dial_mode  = csr_data[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      s1_report_in = s1_report_ff;
      if (req_fire) begin
         s1_report_in.report_length = req_report_length;
         s1_report_in.report_id     = req_report_id;
         s1_report_in.aileron_byte  = req_aileron_byte;
         s1_report_in.elevator_byte = req_elevator_byte;
         s1_report_in.throttle_byte = req_throttle_byte;
         s1_report_in.dial_byte     = req_dial_byte;
         s1_report_in.rudder_byte   = req_rudder_byte;
         s1_report_in.trim_byte     = req_trim_byte;
         s1_report_in.switch_byte   = req_switch_byte;
      end
      s1_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_comb begin
      if (s1_report_ff.report_length != REPORT_LEN) begin
         status_in = STATUS_BAD_LENGTH;
      end else if (s1_report_ff.report_id != REPORT_ID) begin
         status_in = STATUS_BAD_ID;
      end else begin
         status_in = STATUS_OK;
      end
      if (!advance) begin
         status_in = status_ff;
      end
      decode_ok = advance && (status_in == STATUS_OK);

      held_in      = held_ff;
      last_dial_in = last_dial_ff;
      if (decode_ok) begin
         held_in.axis_rudder   = rudder_value;
         held_in.axis_throttle = throttle_value;
         held_in.axis_aileron  = aileron_value;
         held_in.axis_elevator = elevator_value;
         held_in.button_bits   = {trim_buttons, s1_report_ff.switch_byte};
         if (cfg_ff.dial_mode) begin
            held_in.dial_delta = $signed(s1_report_ff.dial_byte - last_dial_ff);
            last_dial_in       = s1_report_ff.dial_byte;
         end else begin
            held_in.axis_aux   = aux_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadzone   <= DEADZONE_RESET;
         cfg_ff.stick_gain <= STICK_GAIN_RESET;
         cfg_ff.dial_mode  <= 1'b0;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         status_ff         <= STATUS_OK;
         held_ff           <= '0;
         last_dial_ff      <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         held_ff      <= held_in;
         last_dial_ff <= last_dial_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_report_ff <= s1_report_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_axis_rudder   = held_ff.axis_rudder;
   assign rsp_axis_throttle = held_ff.axis_throttle;
   assign rsp_axis_aileron  = held_ff.axis_aileron;
   assign rsp_axis_elevator = held_ff.axis_elevator;
   assign rsp_axis_aux      = held_ff.axis_aux;
   assign rsp_dial_delta    = held_ff.dial_delta;
   assign rsp_button_bits   = held_ff.button_bits;

   // rejected report leaves all held values untouched
   assert property (@(posedge clock) disable iff (reset)
      (advance && !decode_ok) |=> ($stable(held_ff) && $stable(last_dial_ff)))
      else $error("held state changed on a rejected report");

   // clamp keeps the aileron and rudder axes within plus or minus one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (held_ff.axis_aileron <= AXIS_ONE
                        && held_ff.axis_aileron >= AXIS_NEG_ONE
                        && held_ff.axis_rudder <= AXIS_ONE
                        && held_ff.axis_rudder >= AXIS_NEG_ONE))
      else $error("axis out of range");

   // aux axis held and dial tracked only in dial mode
   assert property (@(posedge clock) disable iff (reset)
      (decode_ok && cfg_ff.dial_mode) |=> $stable(held_ff.axis_aux))
      else $error("aux axis changed in dial mode");

   assert property (@(posedge clock) disable iff (reset)
      (decode_ok && !cfg_ff.dial_mode) |=> $stable(last_dial_ff))
      else $error("last dial position changed in aux mode");

   // a full input register that cannot drain blocks new beats
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |-> !req_ready)
      else $error("input register overrun");

endmodule
`default_nettype wire
